// ===== rtl/core/efd_pkg.sv =====
package efd_pkg;

	localparam logic [7:0] DELIM_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE = 8'h7D;
	localparam logic [7:0] ESC_XOR = 8'h20;
	localparam logic [7:0] SUM_GOOD = 8'hFF;
	// Delimiter, two length bytes and checksum.
	localparam logic [16:0] FRAME_OVERHEAD = 17'd4;

	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] ADDR_CHECKSUM_CHECK = 3'd0;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END_GOOD = 2'd1,
		KIND_END_BAD = 2'd2
	} result_kind_t;

	typedef struct packed {
		logic has_result;
		result_kind_t kind;
		logic [7:0] data_byte;
		logic [15:0] position;
	} efd_result_t;

endpackage

// ===== rtl/core/efd_frame.sv =====
module efd_frame (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] raw_byte,
	input logic checksum_check,
	output efd_pkg::efd_result_t result
);
	import efd_pkg::*;

	logic in_frame_q;
	logic escape_q;
	logic [16:0] count_q;
	logic [15:0] length_q;
	logic [7:0] sum_q;

	logic is_delim;
	logic is_esc;
	logic [7:0] byte_d;
	logic [16:0] count_next;
	logic [7:0] sum_next;
	logic is_len_hi;
	logic is_len_lo;
	logic is_end;
	logic data_beat;

	assign is_delim = (raw_byte == DELIM_BYTE);
	assign is_esc = (raw_byte == ESC_BYTE);
	assign byte_d = escape_q ? (raw_byte ^ ESC_XOR) : raw_byte;
	assign count_next = count_q + 17'd1;
	assign sum_next = sum_q + byte_d;
	assign is_len_hi = (count_next == 17'd1);
	assign is_len_lo = (count_next == 17'd2);
	// The checksum is the last of length plus overhead bytes.
	assign is_end = (count_next + 17'd1 == {1'b0, length_q} + FRAME_OVERHEAD);
	assign data_beat = !is_delim && in_frame_q && !is_esc;

	always_comb begin
		result.has_result = 1'b0;
		result.kind = KIND_DATA;
		result.data_byte = 8'h00;
		result.position = length_q;
		if (data_beat && !is_len_hi && !is_len_lo) begin
			result.has_result = 1'b1;
			if (is_end) begin
				result.kind = (!checksum_check || sum_next == SUM_GOOD) ?
					KIND_END_GOOD : KIND_END_BAD;
			end else begin
				result.kind = KIND_DATA;
				result.data_byte = byte_d;
				result.position = count_next[15:0] - 16'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			escape_q <= 1'b0;
			count_q <= '0;
			length_q <= '0;
			sum_q <= '0;
		end else if (step) begin
			if (is_delim) begin
				in_frame_q <= 1'b1;
				escape_q <= 1'b0;
				count_q <= '0;
				sum_q <= '0;
			end else if (in_frame_q) begin
				if (is_esc) begin
					escape_q <= 1'b1;
				end else begin
					escape_q <= 1'b0;
					count_q <= count_next;
					if (is_len_hi) begin
						length_q <= {byte_d, 8'h00};
					end else if (is_len_lo) begin
						length_q[7:0] <= byte_d;
					end else if (is_end) begin
						in_frame_q <= 1'b0;
					end else begin
						sum_q <= sum_next;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/escaped_frame_deframer.sv =====
// Escaped API frame deframer.
// Input channel (in_valid, in_stall, rx_byte) takes one raw serial byte per beat.
// Output channel (out_valid, out_stall, result_kind, data_byte, position) gives
// at most one result per input byte: a de-escaped frame data byte with its index,
// or a frame end with checksum verdict and frame length.
// Delimiter, escape and length bytes, and bytes outside a frame, give no result.
// A byte is registered on accept into the input register and is decoded straight
// into the output register once that register is free, so each result passes
// through the input register and then the output register.
// Throughput is one byte per cycle while the receiver does not stall the output.
// When the receiver stalls with a result waiting, one more byte is held in the
// input register and in_stall then rises until the output register drains.
// The APB port holds checksum_check at address 0 (reset 1); write it only while
// the block is idle. Reset clears all frame state, so the block hunts for a
// delimiter, and empties both registers.
module escaped_frame_deframer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic [15:0] position,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [efd_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import efd_pkg::*;

	logic checksum_check_q;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic out_valid_q;
	efd_result_t out_q;
	efd_result_t result;
	logic out_free;
	logic step;
	logic accept;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CHECKSUM_CHECK) ? {31'd0, checksum_check_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_check_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr == ADDR_CHECKSUM_CHECK) begin
			checksum_check_q <= pwdata[0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign step = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	efd_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.raw_byte(byte_s1),
		.checksum_check(checksum_check_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && result.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = out_q.kind;
	assign data_byte = out_q.data_byte;
	assign position = out_q.position;

endmodule
